// ----- rtl/uvs_pkg.sv -----
// Shared types, constants and sequence codes for the UV-sphere triangle index generator.
package uvs_pkg;

  // Field and counter widths
  localparam int RING_W = 8;
  localparam int COL_W  = 9;
  localparam int VERT_W = 17;
  localparam int SEC_W  = 2;

  // Ring setting limits
  localparam int MAX_RINGS_DEF = 200;
  localparam int MIN_RINGS     = 2;

  // Section codes; the fourth code is unused and is treated as a restart
  localparam logic [SEC_W-1:0] SEC_TOP = 2'd0;
  localparam logic [SEC_W-1:0] SEC_MID = 2'd1;
  localparam logic [SEC_W-1:0] SEC_BOT = 2'd2;

  // Walk state of the index sequence
  typedef struct packed {
    logic [SEC_W-1:0]  section;
    logic [RING_W-1:0] ring_counter;
    logic [COL_W-1:0]  column_counter;
    logic              second_half;
    logic [VERT_W-1:0] upper_base;
    logic [VERT_W-1:0] lower_base;
  } uvs_state_t;

  // One emitted triangle
  typedef struct packed {
    logic [VERT_W-1:0] v0;
    logic [VERT_W-1:0] v1;
    logic [VERT_W-1:0] v2;
    logic              last;
  } uvs_tri_t;

  // State at the first top-fan triangle
  localparam uvs_state_t SEQ_START = '{
    section:        SEC_TOP,
    ring_counter:   8'd2,
    column_counter: 9'd0,
    second_half:    1'b0,
    upper_base:     17'd1,
    lower_base:     17'd1
  };

endpackage

// ----- rtl/uvs_req_if.sv -----
// Request channel: valid/ready handshake carrying the restart flag.
interface uvs_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ----- rtl/uvs_tri_if.sv -----
// Triangle channel: valid/ready handshake carrying three vertex indices and the last flag.
interface uvs_tri_if
  import uvs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [VERT_W-1:0] vertex_first;
  logic [VERT_W-1:0] vertex_second;
  logic [VERT_W-1:0] vertex_third;
  logic              last_triangle;

  modport source (output valid, output vertex_first, output vertex_second,
                  output vertex_third, output last_triangle, input ready);
  modport sink   (input valid, input vertex_first, input vertex_second,
                  input vertex_third, input last_triangle, output ready);
endinterface

// ----- rtl/uvs_tri_core.sv -----
// Triangle step logic: vertex indices of the current triangle and the next walk state.
module uvs_tri_core
  import uvs_pkg::*;
(
  input  logic [RING_W-1:0] rings,
  input  logic              restart,
  input  uvs_state_t        st,
  output uvs_state_t        st_next,
  output uvs_tri_t          tri_res
);

  uvs_state_t        cur;
  logic [COL_W-1:0]  cols;
  logic [COL_W-1:0]  i;
  logic [COL_W-1:0]  n;
  logic [COL_W:0]    i_inc;
  logic              row_end;
  logic [RING_W:0]   ring_inc;
  logic [VERT_W-1:0] a;
  logic [VERT_W-1:0] b;
  logic [VERT_W-1:0] a_i;
  logic [VERT_W-1:0] a_n;
  logic [VERT_W-1:0] b_i;
  logic [VERT_W-1:0] b_n;
  logic [VERT_W-1:0] b_c;

  // Column bookkeeping and base sums
  always_comb begin
    if (restart || (st.section != SEC_TOP && st.section != SEC_MID &&
                    st.section != SEC_BOT)) begin
      cur = SEQ_START;
    end else begin
      cur = st;
    end
    cols     = {rings, 1'b0};
    i        = cur.column_counter;
    i_inc    = {1'b0, i} + 1'b1;
    row_end  = (i_inc >= {1'b0, cols});
    n        = row_end ? '0 : i_inc[COL_W-1:0];
    ring_inc = {1'b0, cur.ring_counter} + 1'b1;
    a        = cur.upper_base;
    b        = cur.lower_base;
    a_i      = a + VERT_W'(i);
    a_n      = a + VERT_W'(n);
    b_i      = b + VERT_W'(i);
    b_n      = b + VERT_W'(n);
    b_c      = b + VERT_W'(cols);
  end

  // Pick the triangle and advance the walk by section
  always_comb begin
    st_next      = cur;
    tri_res.last = 1'b0;
    case (cur.section)
      SEC_TOP: begin
        tri_res.v0 = '0;
        tri_res.v1 = VERT_W'(i) + 1'b1;
        tri_res.v2 = VERT_W'(n) + 1'b1;
        if (row_end) begin
          st_next.column_counter = '0;
          st_next.upper_base     = VERT_W'(1);
          st_next.lower_base     = VERT_W'(cols) + 1'b1;
          st_next.ring_counter   = RING_W'(2);
          st_next.section        = (rings > RING_W'(2)) ? SEC_MID : SEC_BOT;
        end else begin
          st_next.column_counter = i_inc[COL_W-1:0];
        end
      end
      SEC_MID: begin
        tri_res.v0 = a_i;
        if (!cur.second_half) begin
          tri_res.v1          = b_i;
          tri_res.v2          = b_n;
          st_next.second_half = 1'b1;
        end else begin
          tri_res.v1          = b_n;
          tri_res.v2          = a_n;
          st_next.second_half = 1'b0;
          if (row_end) begin
            st_next.column_counter = '0;
            st_next.upper_base     = b;
            st_next.lower_base     = b_c;
            st_next.ring_counter   = ring_inc[RING_W-1:0];
            if (ring_inc >= {1'b0, rings}) begin
              st_next.section = SEC_BOT;
            end
          end else begin
            st_next.column_counter = i_inc[COL_W-1:0];
          end
        end
      end
      default: begin
        tri_res.v0 = a_n;
        tri_res.v1 = a_i;
        tri_res.v2 = b;
        if (row_end) begin
          tri_res.last = 1'b1;
          st_next      = SEQ_START;
        end else begin
          st_next.column_counter = i_inc[COL_W-1:0];
        end
      end
    endcase
  end

endmodule

// ----- rtl/uv_sphere_triangle_index_generator.sv -----
// Top level of the UV-sphere triangle index generator: walk state, ring register, result register.
//
//   channel   dir   handshake        payload
//   req       in    valid / ready    restart
//   tri_out   out   valid / ready    vertex_first, vertex_second, vertex_third, last_triangle
//   cfg       in    cfg_wr_en        cfg_wr_data (ring count, clamped to 2..MAX_RINGS)
//
// One request yields one triangle, registered and shown in the cycle after it is taken; a new request is taken
// every cycle, limited only by the single result register draining.
// Reset (rst, synchronous) sets the ring count to 2 and the walk to the first top triangle.
// A held result stalls the request side only when tri_out.ready is low.
// A ring write restarts the walk at the first top triangle.
module uv_sphere_triangle_index_generator
  import uvs_pkg::*;
#(
  parameter int MAX_RINGS = MAX_RINGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [RING_W-1:0] cfg_wr_data,
  uvs_req_if.sink           req,
  uvs_tri_if.source         tri_out
);

  logic [RING_W-1:0] rings;
  logic [RING_W-1:0] rings_next;
  uvs_state_t        walk;
  uvs_state_t        walk_next;
  uvs_tri_t          tri_res;
  uvs_tri_t          result;
  logic              out_valid;
  logic              req_take;

  uvs_tri_core u_core (
    .rings   (rings),
    .restart (req.restart),
    .st      (walk),
    .st_next (walk_next),
    .tri_res (tri_res)
  );

  // Take a request whenever the result register is free or draining
  assign req.ready = !out_valid || tri_out.ready;
  assign req_take  = req.valid && req.ready;

  // Clamp the written ring count
  always_comb begin
    if (cfg_wr_data < RING_W'(MIN_RINGS)) begin
      rings_next = RING_W'(MIN_RINGS);
    end else if (cfg_wr_data > RING_W'(MAX_RINGS)) begin
      rings_next = RING_W'(MAX_RINGS);
    end else begin
      rings_next = cfg_wr_data;
    end
  end

  // Hold ring count and walk state; a ring write restarts the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rings <= RING_W'(MIN_RINGS);
      walk  <= SEQ_START;
    end else if (cfg_wr_en) begin
      rings <= rings_next;
      walk  <= SEQ_START;
    end else if (req_take) begin
      walk  <= walk_next;
    end
  end

  // Result register: load on a taken request, drop when taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_take) begin
      out_valid <= 1'b1;
    end else if (tri_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      result <= tri_res;
    end
  end

  assign tri_out.valid         = out_valid;
  assign tri_out.vertex_first  = result.v0;
  assign tri_out.vertex_second = result.v1;
  assign tri_out.vertex_third  = result.v2;
  assign tri_out.last_triangle = result.last;

endmodule

// ----- rtl/uvs_checker.sv -----
// Port-level checks for the UV-sphere triangle index generator, bound to the top level.
module uvs_checker
  import uvs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              restart,
  input logic              out_valid,
  input logic              out_ready,
  input logic [VERT_W-1:0] vertex_first,
  input logic [VERT_W-1:0] vertex_second,
  input logic [VERT_W-1:0] vertex_third,
  input logic              last_triangle
);

  // A stalled triangle holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vertex_first) &&
      $stable(vertex_second) && $stable(vertex_third) && $stable(last_triangle))
    else $error("stalled triangle changed");

  // Every taken request shows a triangle in the next cycle
  a_req_to_tri: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("request taken without a triangle");

  // A restart request emits the first top triangle
  a_restart_first: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && restart |=>
      vertex_first == '0 && vertex_second == VERT_W'(1) && vertex_third == VERT_W'(2))
    else $error("restart did not emit the first top triangle");

  // The final bottom triangle has rising indices
  a_last_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_triangle |->
      vertex_first < vertex_second && vertex_second < vertex_third)
    else $error("final triangle out of order");

  // An empty result register never blocks a request
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request blocked with no pending triangle");

endmodule

bind uv_sphere_triangle_index_generator uvs_checker u_uvs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (req.valid),
  .in_ready      (req.ready),
  .restart       (req.restart),
  .out_valid     (tri_out.valid),
  .out_ready     (tri_out.ready),
  .vertex_first  (tri_out.vertex_first),
  .vertex_second (tri_out.vertex_second),
  .vertex_third  (tri_out.vertex_third),
  .last_triangle (tri_out.last_triangle)
);

// ----- test/uvs_checker.sv -----
// Checker for the UV-sphere index generator: predicts each triangle and compares the output.
`timescale 1ns / 100ps

module uvs_tb_checker
  import uvs_pkg::*;
#(
  parameter int MAX_RINGS = MAX_RINGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [RING_W-1:0] cfg_wr_data,
  uvs_req_if                req,
  uvs_tri_if                tri_out,
  output int                pending,
  output int                fail_count,
  output int                sphere_count
);

  // Predicted walk state and ring setting
  uvs_state_t  walk;
  int unsigned rings;

  // Triangles owed by the block, oldest first
  uvs_tri_t tri_q[$];
  uvs_tri_t want_tri;
  uvs_tri_t got_tri;

  // Advance the walk by one request and return the triangle it emits
  function automatic uvs_tri_t next_triangle(input logic restart);
    uvs_tri_t    t;
    int unsigned cols;
    int unsigned col;
    int unsigned nxt;
    int unsigned up;
    int unsigned lo;
    logic        wrap;
    if (restart || walk.section > SEC_BOT) walk = SEQ_START;
    cols = 2 * rings;
    col = walk.column_counter;
    wrap = (col + 1 >= cols);
    nxt = wrap ? 0 : col + 1;
    up = walk.upper_base;
    lo = walk.lower_base;
    t.last = 1'b0;
    case (walk.section)
      SEC_TOP: begin
        // Fan around the top pole
        t.v0 = '0;
        t.v1 = VERT_W'(1 + col);
        t.v2 = VERT_W'(1 + nxt);
        if (wrap) begin
          walk.column_counter = '0;
          walk.upper_base = VERT_W'(1);
          walk.lower_base = VERT_W'(1 + cols);
          walk.ring_counter = RING_W'(MIN_RINGS);
          walk.section = (rings > MIN_RINGS) ? SEC_MID : SEC_BOT;
        end else begin
          walk.column_counter = COL_W'(col + 1);
        end
      end
      SEC_MID: begin
        // Two triangles per quad between the upper and lower ring
        if (!walk.second_half) begin
          t.v0 = VERT_W'(up + col);
          t.v1 = VERT_W'(lo + col);
          t.v2 = VERT_W'(lo + nxt);
          walk.second_half = 1'b1;
        end else begin
          t.v0 = VERT_W'(up + col);
          t.v1 = VERT_W'(lo + nxt);
          t.v2 = VERT_W'(up + nxt);
          walk.second_half = 1'b0;
          if (wrap) begin
            walk.column_counter = '0;
            walk.upper_base = VERT_W'(lo);
            walk.lower_base = VERT_W'(lo + cols);
            walk.ring_counter = RING_W'(walk.ring_counter + 1);
            if (walk.ring_counter >= rings) walk.section = SEC_BOT;
          end else begin
            walk.column_counter = COL_W'(col + 1);
          end
        end
      end
      default: begin
        // Fan around the bottom pole; the last one wraps to the top
        t.v0 = VERT_W'(up + nxt);
        t.v1 = VERT_W'(up + col);
        t.v2 = VERT_W'(lo);
        if (wrap) begin
          t.last = 1'b1;
          walk = SEQ_START;
        end else begin
          walk.column_counter = COL_W'(col + 1);
        end
      end
    endcase
    return t;
  endfunction

  // Check results, track ring writes, predict accepted requests
  always @(posedge clk) begin
    if (rst) begin
      walk = SEQ_START;
      rings = MIN_RINGS;
      tri_q.delete();
      fail_count = 0;
      sphere_count = 0;
    end else begin
      if (tri_out.valid && tri_out.ready) begin
        got_tri.v0 = tri_out.vertex_first;
        got_tri.v1 = tri_out.vertex_second;
        got_tri.v2 = tri_out.vertex_third;
        got_tri.last = tri_out.last_triangle;
        if (tri_q.size() == 0) begin
          $display("%0t: triangle (%0d %0d %0d last %0b) with nothing expected",
                   $time, got_tri.v0, got_tri.v1, got_tri.v2, got_tri.last);
          fail_count++;
        end else begin
          want_tri = tri_q.pop_front();
          if (got_tri.v0 !== want_tri.v0 || got_tri.v1 !== want_tri.v1 ||
              got_tri.v2 !== want_tri.v2 || got_tri.last !== want_tri.last) begin
            $display({"%0t: triangle mismatch, expected (%0d %0d %0d last %0b), ",
                      "got (%0d %0d %0d last %0b)"},
                     $time, want_tri.v0, want_tri.v1, want_tri.v2, want_tri.last,
                     got_tri.v0, got_tri.v1, got_tri.v2, got_tri.last);
            fail_count++;
          end else if (want_tri.last) begin
            sphere_count++;
          end
        end
      end
      // Ring write: clamp and restart the walk
      if (cfg_wr_en) begin
        rings = cfg_wr_data;
        if (rings < MIN_RINGS) rings = MIN_RINGS;
        if (rings > MAX_RINGS) rings = MAX_RINGS;
        walk = SEQ_START;
      end
      if (req.valid && req.ready) tri_q.insert(tri_q.size(), next_triangle(req.restart));
    end
    pending = tri_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the UV-sphere index generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top
  import uvs_pkg::*;
();

  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 125;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int FULL_RINGS    = 6;
  localparam int FULL_SPHERE   = 4 * FULL_RINGS * (FULL_RINGS - 1);

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [RING_W-1:0] cfg_wr_data;
  logic              hold_off;

  int pending;
  int fail_count;
  int sphere_count;
  int send_idle;
  int recv_idle;
  int request_count;
  int setting_count;

  // Ring writes of the random phases but the last: clamp cases, small spheres, the maximum
  logic [RING_W-1:0] ring_plan [RAND_PHASES] = '{8'd0, 8'd3, 8'd4, 8'd255, 8'd1, 8'd5,
                                                 8'd201, 8'd6, 8'd2, 8'd4, 8'd3, 8'd7};

  uvs_req_if req();
  uvs_tri_if tri_out();

  uv_sphere_triangle_index_generator u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .tri_out     (tri_out)
  );

  uvs_tb_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .req          (req),
    .tri_out      (tri_out),
    .pending      (pending),
    .fail_count   (fail_count),
    .sphere_count (sphere_count)
  );

  always #5 clk = ~clk;

  // Receiver: random back-pressure, or one long hold when asked
  initial begin
    tri_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off <= 1'b0;
        tri_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        tri_out.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic restart);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.restart <= restart;
    do @(posedge clk); while (!req.ready);
    request_count++;
  endtask

  // Drop valid and wait until every triangle has come out
  task automatic drain();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the ring count once the block is idle
  task automatic write_rings(input logic [RING_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    setting_count++;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    req.valid <= 1'b0;
    req.restart <= 1'b0;
    hold_off <= 1'b0;
    send_idle = 0;
    recv_idle = 0;
    request_count = 0;
    setting_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset ring count: a full sphere, wrap to the top, restarts mid-walk and back to back
    repeat (9) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);

    // Three rings: top fan into the first middle quads, then a restart
    write_rings(8'd3);
    repeat (9) send_request(1'b0);
    send_request(1'b1);

    // Random phases: mostly plain walks, a few restarts
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < RAND_PHASES / 3) begin
        send_idle = 10;
        recv_idle = 67;
      end else if (p < 2 * RAND_PHASES / 3) begin
        send_idle = 67;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == RAND_PHASES - 1) write_rings(RING_W'($urandom_range(2, 8)));
      else write_rings(ring_plan[p]);
      if (p == 1) hold_off <= 1'b1;
      repeat (PHASE_ITEMS) send_request($urandom_range(99) < 2);
    end

    // One mid-size sphere end to end, plus the wrap into the first two triangles of the next top fan
    send_idle = 0;
    recv_idle = 0;
    write_rings(RING_W'(FULL_RINGS));
    repeat (FULL_SPHERE + 2) send_request(1'b0);
    drain();

    $display("covered %0d requests over %0d ring writes, clamped extremes up to %0d rings",
             request_count, setting_count, MAX_RINGS_DEF);
    $display("checked %0d complete spheres under idling on both sides and a long output hold",
             sphere_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/uvs_pkg.sv
rtl/uvs_req_if.sv
rtl/uvs_tri_if.sv
rtl/uvs_tri_core.sv
rtl/uv_sphere_triangle_index_generator.sv
rtl/uvs_checker.sv
test/uvs_checker.sv
test/tb_top.sv
